// ===== hdl/dtts_pkg.sv =====
`timescale 1ns / 1ps

package dtts_pkg;

	typedef enum logic [2:0] {
		OP_DIGIT,
		OP_SKIP,
		OP_HOUR,
		OP_MIN,
		OP_SEC,
		OP_BAD
	} op_kind_t;

	typedef struct packed {
		op_kind_t    kind;
		logic [3:0]  digit;
		logic        last;
	} op_t;

	localparam int QUEUE_DEPTH = 4;

	localparam int SCALE_W = 12;
	localparam logic [SCALE_W-1:0] SCALE_HOUR = 12'd3600;
	localparam logic [SCALE_W-1:0] SCALE_MIN  = 12'd60;
	localparam logic [SCALE_W-1:0] SCALE_SEC  = 12'd1;

	localparam int TOTAL_W = 64;

endpackage

// ===== hdl/dtts_front.sv =====
`timescale 1ns / 1ps

module dtts_front (
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        ch,
	input  logic              last,
	output logic              push,
	output dtts_pkg::op_t     push_op,
	input  logic              queue_ready
);
	import dtts_pkg::*;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_UH    = 8'h48;
	localparam logic [7:0] CHAR_LH    = 8'h68;
	localparam logic [7:0] CHAR_UM    = 8'h4d;
	localparam logic [7:0] CHAR_LM    = 8'h6d;
	localparam logic [7:0] CHAR_US    = 8'h53;
	localparam logic [7:0] CHAR_LS    = 8'h73;

	op_kind_t kind;

	always_comb begin
		if (ch inside {[CHAR_ZERO:CHAR_NINE]}) begin
			kind = OP_DIGIT;
		end else if (ch inside {CHAR_SPACE, CHAR_TAB}) begin
			kind = OP_SKIP;
		end else if (ch inside {CHAR_UH, CHAR_LH}) begin
			kind = OP_HOUR;
		end else if (ch inside {CHAR_UM, CHAR_LM}) begin
			kind = OP_MIN;
		end else if (ch inside {CHAR_US, CHAR_LS}) begin
			kind = OP_SEC;
		end else begin
			kind = OP_BAD;
		end
	end

	// blanks in mid string need no slot in the queue
	assign in_ready      = queue_ready;
	assign push          = in_valid && queue_ready && !(kind == OP_SKIP && !last);
	assign push_op.kind  = kind;
	assign push_op.digit = ch[3:0];
	assign push_op.last  = last;

endmodule

// ===== hdl/dtts_queue.sv =====
`timescale 1ns / 1ps

module dtts_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dtts_pkg::op_t     push_op,
	output logic              push_ready,
	input  logic              pop,
	output dtts_pkg::op_t     pop_op,
	output logic              pop_valid
);
	import dtts_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	op_t              slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign push_ready = count_q != CNT_FULL;
	assign pop_valid  = count_q != '0;
	assign pop_op     = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/dtts_back.sv =====
`timescale 1ns / 1ps

module dtts_back #(
	parameter int NUMBER_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          op_valid,
	input  dtts_pkg::op_t                 op,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [dtts_pkg::TOTAL_W-1:0]  total_seconds,
	output logic                          bad_text
);
	import dtts_pkg::*;

	localparam int WIDE_W = NUMBER_BITS + 4;
	localparam int PROD_W = NUMBER_BITS + SCALE_W;

	logic [TOTAL_W-1:0]     sum_q;
	logic [NUMBER_BITS-1:0] pending_q;
	logic                   seen_q;
	logic                   failed_q;
	logic                   out_valid_q;
	logic [TOTAL_W-1:0]     total_q;
	logic                   bad_q;

	logic                   is_unit;
	logic [SCALE_W-1:0]     scale;
	logic [PROD_W-1:0]      prod;
	logic [WIDE_W-1:0]      wide_next;
	logic [NUMBER_BITS-1:0] pending_sat;
	logic [NUMBER_BITS-1:0] pending_n;
	logic                   seen_n;
	logic                   failed_n;
	logic [TOTAL_W-1:0]     add_term;
	logic [TOTAL_W-1:0]     sum_plus;
	logic [TOTAL_W-1:0]     sum_n;

	assign pop = op_valid && (!op.last || !out_valid_q || out_ready);

	always_comb begin
		case (op.kind)
			OP_HOUR: scale = SCALE_HOUR;
			OP_MIN:  scale = SCALE_MIN;
			default: scale = SCALE_SEC;
		endcase
	end

	assign is_unit   = op.kind inside {OP_HOUR, OP_MIN, OP_SEC};
	assign prod      = PROD_W'(pending_q) * PROD_W'(scale);
	assign wide_next = WIDE_W'({pending_q, 3'b000}) + WIDE_W'({pending_q, 1'b0})
		+ WIDE_W'(op.digit);
	assign pending_sat = (wide_next[WIDE_W-1:NUMBER_BITS] != '0) ? '1
		: wide_next[NUMBER_BITS-1:0];

	always_comb begin
		pending_n = pending_q;
		seen_n    = seen_q;
		failed_n  = failed_q;
		add_term  = '0;
		if (!failed_q) begin
			case (op.kind)
				OP_DIGIT: begin
					pending_n = pending_sat;
					seen_n    = 1'b1;
				end
				OP_SKIP: begin
				end
				OP_HOUR, OP_MIN, OP_SEC: begin
					if (seen_q) begin
						pending_n = '0;
						seen_n    = 1'b0;
						add_term  = TOTAL_W'(prod);
					end else begin
						failed_n = 1'b1;
					end
				end
				default: begin
					failed_n = 1'b1;
				end
			endcase
			// an open number at the end counts as seconds
			if (op.last && !is_unit && seen_n) begin
				add_term = TOTAL_W'(pending_n);
			end
		end
	end

	assign sum_plus = sum_q + add_term;
	assign sum_n    = (is_unit && !failed_q && seen_q) ? sum_plus : sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			pending_q   <= '0;
			seen_q      <= 1'b0;
			failed_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (op.last) begin
					sum_q       <= '0;
					pending_q   <= '0;
					seen_q      <= 1'b0;
					failed_q    <= 1'b0;
					out_valid_q <= 1'b1;
				end else begin
					sum_q     <= sum_n;
					pending_q <= pending_n;
					seen_q    <= seen_n;
					failed_q  <= failed_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && op.last) begin
			total_q <= failed_n ? '0 : sum_plus;
			bad_q   <= failed_n;
		end
	end

	assign out_valid     = out_valid_q;
	assign total_seconds = total_q;
	assign bad_text      = bad_q;

endmodule

// ===== hdl/duration_text_to_seconds.sv =====
`timescale 1ns / 1ps
// the last character of a request goes through the queue to the back end, which registers the result
// throughput: one character per cycle while the queue has room; a last character waits while a result is stalled
// a four-entry queue lets the front keep taking characters while a result is stalled
// reset: arst_n clears the queue, the parse state and the result valid at once

module duration_text_to_seconds #(
	parameter int NUMBER_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    ch,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [dtts_pkg::TOTAL_W-1:0]  total_seconds,
	output logic                          bad_text
);
	import dtts_pkg::*;

	logic push;
	op_t  push_op;
	logic queue_ready;
	logic pop;
	op_t  pop_op;
	logic pop_valid;

	dtts_front u_front (
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.ch          (ch),
		.last        (last),
		.push        (push),
		.push_op     (push_op),
		.queue_ready (queue_ready)
	);

	dtts_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_op    (push_op),
		.push_ready (queue_ready),
		.pop        (pop),
		.pop_op     (pop_op),
		.pop_valid  (pop_valid)
	);

	dtts_back #(
		.NUMBER_BITS (NUMBER_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.op_valid      (pop_valid),
		.op            (pop_op),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.total_seconds (total_seconds),
		.bad_text      (bad_text)
	);

endmodule

// ===== hdl/dtts_checker.sv =====
`timescale 1ns / 1ps

module dtts_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic                          last,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [dtts_pkg::TOTAL_W-1:0]  total_seconds,
	input  logic                          bad_text
);
	import dtts_pkg::*;

	localparam int OPEN_W = $clog2(QUEUE_DEPTH + 3);
	localparam logic [OPEN_W-1:0] OPEN_MAX = OPEN_W'(QUEUE_DEPTH + 1);

	logic [OPEN_W-1:0] open_q;
	logic              req_end;
	logic              res_done;

	assign req_end  = in_valid && in_ready && last;
	assign res_done = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else if (req_end && !res_done) begin
			open_q <= open_q + 1'b1;
		end else if (res_done && !req_end) begin
			open_q <= open_q - 1'b1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(total_seconds) && $stable(bad_text))
		else $error("result changed while stalled");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_text |-> total_seconds == '0)
		else $error("bad text with nonzero total");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> open_q != '0)
		else $error("result without a finished request");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= OPEN_MAX)
		else $error("more requests open than the design can hold");

endmodule

bind duration_text_to_seconds dtts_checker u_dtts_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.last          (last),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.total_seconds (total_seconds),
	.bad_text      (bad_text)
);

// ===== tb/duration_text_to_seconds_check.sv =====
`timescale 1ns / 1ps

module duration_text_to_seconds_check #(
	parameter int NUMBER_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [7:0]                    ch,
	input  logic                          last,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [dtts_pkg::TOTAL_W-1:0]  total_seconds,
	input  logic                          bad_text,
	output int unsigned                   failures,
	output int unsigned                   outstanding
);

	import dtts_pkg::*;

	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_GAP   = 8'h20;
	localparam logic [7:0] CH_H       = 8'h68;
	localparam logic [7:0] CH_M       = 8'h6D;
	localparam logic [7:0] CH_S       = 8'h73;

	localparam logic [63:0] NUMBER_MAX = (64'd1 << NUMBER_BITS) - 64'd1;

	typedef struct {
		logic [TOTAL_W-1:0] total;
		logic               bad;
	} duration_t;

	logic [TOTAL_W-1:0]     sum_so_far;
	logic [NUMBER_BITS-1:0] number;
	logic                   digits_open;
	logic                   broken;
	duration_t              expected_durations[$];
	int unsigned            error_count = 0;

	initial begin
		failures = 0;
		outstanding = 0;
	end

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		if (error_count < 40)
			$display("%0t ns %s: got %0d want %0d", $realtime, what, got, want);
		error_count++;
	endtask

	task automatic clear_parse();
		sum_so_far = '0;
		number = '0;
		digits_open = 1'b0;
		broken = 1'b0;
	endtask

	task automatic parse_char(input logic [7:0] raw);
		logic [7:0]  c;
		logic [63:0] grown;
		logic [63:0] scale;
		c = raw;
		if (broken) begin
		end else if (c >= CH_ZERO && c <= CH_NINE) begin
			grown = 64'(number) * 64'd10 + 64'(c - CH_ZERO);
			number = (grown > NUMBER_MAX) ? NUMBER_MAX[NUMBER_BITS-1:0] : grown[NUMBER_BITS-1:0];
			digits_open = 1'b1;
		end else if (c != CH_SPACE && c != CH_TAB) begin
			if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
				c = c + CASE_GAP;
			if (digits_open && (c == CH_H || c == CH_M || c == CH_S)) begin
				scale = (c == CH_H) ? 64'(SCALE_HOUR) : (c == CH_M) ? 64'(SCALE_MIN) : 64'(SCALE_SEC);
				sum_so_far = sum_so_far + 64'(number) * scale;
				number = '0;
				digits_open = 1'b0;
			end else begin
				broken = 1'b1;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		duration_t want;
		duration_t made;
		if (!arst_n) begin
			clear_parse();
			expected_durations.delete();
			failures <= 0;
			outstanding <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_durations.size() == 0) begin
					report("result with no request pending", total_seconds, 64'd0);
				end else begin
					want = expected_durations.pop_front();
					if (total_seconds !== want.total)
						report("total_seconds", total_seconds, want.total);
					if (bad_text !== want.bad)
						report("bad_text", 64'(bad_text), 64'(want.bad));
				end
			end
			if (in_valid && in_ready) begin
				parse_char(ch);
				if (last) begin
					made.bad = broken;
					if (broken)
						made.total = '0;
					else
						made.total = digits_open ? sum_so_far + 64'(number) : sum_so_far;
					expected_durations.push_back(made);
					clear_parse();
				end
			end
			failures <= error_count;
			outstanding <= expected_durations.size();
		end
	end

endmodule

// ===== tb/duration_text_to_seconds_test.sv =====
`timescale 1ns / 1ps

module duration_text_to_seconds_test;

	import dtts_pkg::*;

	localparam int          NUMBER_BITS = 32;
	localparam int unsigned TARGET_CHARS = 1150;
	localparam int unsigned QUIET_LIMIT = 2000;

	localparam logic [7:0]  CH_TAB   = 8'h09;
	localparam logic [7:0]  CH_SPACE = 8'h20;
	localparam logic [7:0]  CH_ZERO  = 8'h30;
	localparam logic [7:0]  CH_LOWER_A = 8'h61;
	localparam logic [47:0] UNIT_CHARS = "hmsHMS";

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [7:0]          ch = '0;
	logic                last = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [TOTAL_W-1:0]  total_seconds;
	logic                bad_text;
	int unsigned         failures;
	int unsigned         outstanding;

	logic [7:0]          text[$];
	int unsigned         sent_chars = 0;
	int unsigned         stall = 0;
	int unsigned         quiet_cycles = 0;
	bit                  calm = 1'b0;

	always #2 clk = ~clk;

	duration_text_to_seconds #(
		.NUMBER_BITS(NUMBER_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.ch(ch),
		.last(last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.total_seconds(total_seconds),
		.bad_text(bad_text)
	);

	duration_text_to_seconds_check #(
		.NUMBER_BITS(NUMBER_BITS)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.ch(ch),
		.last(last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.total_seconds(total_seconds),
		.bad_text(bad_text),
		.failures(failures),
		.outstanding(outstanding)
	);

	// result side: each result draws its own stall
	always @(posedge clk) begin : sink
		int unsigned pause;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall <= 0;
		end else if (out_valid && out_ready) begin
			pause = calm ? 0 : $urandom_range(0, 9);
			stall <= pause;
			out_ready <= (pause == 0);
		end else if (stall > 1) begin
			stall <= stall - 1;
		end else begin
			stall <= 0;
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("duration_text_to_seconds: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic push_char(input logic [7:0] c, input logic is_last);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		ch <= c;
		last <= is_last;
		do @(posedge clk); while (!in_ready);
		sent_chars++;
	endtask

	task automatic send_text();
		foreach (text[k])
			push_char(text[k], k == text.size() - 1);
	endtask

	task automatic send_string(input string s);
		text.delete();
		for (int i = 0; i < s.len(); i++)
			text.push_back(s[i]);
		send_text();
	endtask

	task automatic add_blank();
		text.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
	endtask

	function automatic logic [7:0] any_unit();
		return UNIT_CHARS[8 * $urandom_range(0, 5) +: 8];
	endfunction

	task automatic make_duration();
		int unsigned tokens;
		int unsigned ndig;
		text.delete();
		if ($urandom_range(0, 19) == 0) begin
			repeat ($urandom_range(1, 5)) text.push_back(8'($urandom_range(0, 255)));
		end else begin
			if ($urandom_range(0, 7) == 0)
				add_blank();
			tokens = $urandom_range(1, 4);
			for (int t = 0; t < tokens; t++) begin
				ndig = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 4);
				for (int d = 0; d < ndig; d++) begin
					if (d != 0 && $urandom_range(0, 15) == 0)
						add_blank();
					text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
				end
				if ($urandom_range(0, 3) == 0)
					add_blank();
				if (t != tokens - 1 || $urandom_range(0, 4) != 0)
					text.push_back(any_unit());
				if ($urandom_range(0, 3) == 0)
					add_blank();
			end
			// corruptions: stray byte, unit with no number, wrong letter
			if ($urandom_range(0, 5) == 0)
				text.insert($urandom_range(0, text.size()), 8'($urandom_range(0, 255)));
			else if ($urandom_range(0, 9) == 0)
				text.push_front(any_unit());
			if ($urandom_range(0, 9) == 0)
				text[$urandom_range(0, text.size() - 1)] = CH_LOWER_A + 8'($urandom_range(0, 25));
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		calm = 1'b1;
		send_string("1H 3m");
		calm = 1'b0;
		send_string("9\t2s");
		send_string("m");
		send_string("5x7");
		send_string("7:");
		send_string("\377");
		send_string(" ");
		send_string("4294967296");

		while (sent_chars < TARGET_CHARS) begin
			calm = ($urandom_range(0, 5) == 0);
			make_duration();
			send_text();
		end
		in_valid <= 1'b0;
		last <= 1'b0;

		do @(posedge clk); while (outstanding != 0);
		repeat (8) @(posedge clk);
		if (failures == 0 && outstanding == 0)
			$display("duration_text_to_seconds: match");
		else
			$display("duration_text_to_seconds: mismatch");
		$finish;
	end

endmodule
